### src/mbdh_pkg.sv
`default_nettype none

package mbdh_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_TICK_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_ENABLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_ENABLE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UP_ENABLE      = 3'd5;

  // reset values, masks cut down to the button count where used
  localparam logic [CFG_TICK_W-1:0] DEBOUNCE_RST    = 16'd50;
  localparam logic [CFG_TICK_W-1:0] HOLD_RST        = 16'd3000;
  localparam logic [31:0]           PRESSED_LVL_RST = 32'd0;
  localparam logic [31:0]           DOWN_EN_RST     = 32'd15;
  localparam logic [31:0]           HOLD_EN_RST     = 32'd8;
  localparam logic [31:0]           UP_EN_RST       = 32'd0;

  // events of one button for one tick
  typedef struct packed {
    logic press;
    logic hold;
    logic release_ev;
    logic down;
  } lane_evt_t;

endpackage

`default_nettype wire

### src/multi_button_debounce_hold_top.sv
`default_nettype none

// multi-button debouncer with hold and hold repeat
// - input channel: one beat per timer tick, in_pin_levels holds the raw pin
//   level of each button (bit i is button i); in_valid / in_stall handshake
// - result channel: exactly one beat per input beat with press, hold and
//   release event bits (gated by the enable masks) and the debounced down
//   state after that tick; out_valid / out_stall handshake
// - config channel: cfg_valid / cfg_ready with cfg_index and cfg_wdata;
//   cfg_ready is always high, write only while no tick is in flight
// - pipeline: an accepted tick is held in the input register, then the
//   per-button update writes its result into the result register, from
//   which its result beat is taken
// - throughput: one tick per cycle while out_stall is low; the per-button
//   compare and counter step between input and result register sets it
// - stall: while out_stall holds a result, the input register keeps its
//   beat and in_stall goes high only when that register is also full
// - reset: all buttons go to the up state, counters to zero, registers to
//   their reset values, both pipeline registers empty
module multi_button_debounce_hold_top #(
  parameter int NUM_BUTTONS = 4,
  parameter int COUNT_BITS  = 16,
  parameter int CFG_W       = (NUM_BUTTONS > 16) ? NUM_BUTTONS : 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // tick channel
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [NUM_BUTTONS-1:0]         in_pin_levels,
  // result channel
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic [NUM_BUTTONS-1:0]         out_press_events,
  output      logic [NUM_BUTTONS-1:0]         out_hold_events,
  output      logic [NUM_BUTTONS-1:0]         out_release_events,
  output      logic [NUM_BUTTONS-1:0]         out_debounced_down,
  // config channel
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [mbdh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]               cfg_wdata
);
  import mbdh_pkg::*;

  logic [COUNT_BITS-1:0]  dload;
  logic [COUNT_BITS-1:0]  hload;
  logic [NUM_BUTTONS-1:0] pressed_lvl;
  logic [NUM_BUTTONS-1:0] down_en;
  logic [NUM_BUTTONS-1:0] hold_en;
  logic [NUM_BUTTONS-1:0] up_en;

  // input register
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic [NUM_BUTTONS-1:0] pins_r;

  // result register
  logic                   out_valid_r;
  logic [NUM_BUTTONS-1:0] press_r;
  logic [NUM_BUTTONS-1:0] hold_r;
  logic [NUM_BUTTONS-1:0] release_r;
  logic [NUM_BUTTONS-1:0] down_r;

  logic                   advance;
  logic                   step;
  logic                   in_take;
  logic [NUM_BUTTONS-1:0] active;
  lane_evt_t              evt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] press_raw;
  logic [NUM_BUTTONS-1:0] hold_raw;
  logic [NUM_BUTTONS-1:0] release_raw;
  logic [NUM_BUTTONS-1:0] down_raw;

  mbdh_cfg #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .COUNT_BITS  (COUNT_BITS),
    .CFG_W       (CFG_W)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .dload       (dload),
    .hload       (hload),
    .pressed_lvl (pressed_lvl),
    .down_en     (down_en),
    .hold_en     (hold_en),
    .up_en       (up_en)
  );

  // result register can take a new beat when empty or being drained
  assign advance  = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // a button is active when its pin sits at the pressed level
  assign active = ~(pins_r ^ pressed_lvl);

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    mbdh_lane #(
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .step   (step),
      .active (active[b]),
      .dload  (dload),
      .hload  (hload),
      .evt    (evt[b])
    );
    assign press_raw[b]   = evt[b].press;
    assign hold_raw[b]    = evt[b].hold;
    assign release_raw[b] = evt[b].release_ev;
    assign down_raw[b]    = evt[b].down;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      pins_r <= in_pin_levels;
    end
    if (step) begin
      press_r   <= press_raw & down_en;
      hold_r    <= hold_raw & hold_en;
      release_r <= release_raw & up_en;
      down_r    <= down_raw;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_press_events   = press_r;
  assign out_hold_events    = hold_r;
  assign out_release_events = release_r;
  assign out_debounced_down = down_r;

`ifndef SYNTH
  a_tick_reaches_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("ticked beat did not reach the result register");

  a_no_press_and_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_press_events & out_release_events) == '0))
    else $error("press and release on the same button in one beat");

  a_press_means_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_press_events & ~out_debounced_down) == '0))
    else $error("press reported for a button that is not down");

  a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> (s1_valid_r && $stable(pins_r)))
    else $error("input register lost its beat under a stall");
`endif

endmodule

`default_nettype wire

### src/mbdh_cfg.sv
`default_nettype none

module mbdh_cfg #(
  parameter int NUM_BUTTONS = 4,
  parameter int COUNT_BITS  = 16,
  parameter int CFG_W       = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [mbdh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]               cfg_wdata,
  output      logic [COUNT_BITS-1:0]          dload,
  output      logic [COUNT_BITS-1:0]          hload,
  output      logic [NUM_BUTTONS-1:0]         pressed_lvl,
  output      logic [NUM_BUTTONS-1:0]         down_en,
  output      logic [NUM_BUTTONS-1:0]         hold_en,
  output      logic [NUM_BUTTONS-1:0]         up_en
);
  import mbdh_pkg::*;

  logic [CFG_TICK_W-1:0]    debounce_r;
  logic [CFG_TICK_W-1:0]    hold_ticks_r;
  logic [NUM_BUTTONS-1:0]   pressed_lvl_r;
  logic [NUM_BUTTONS-1:0]   down_en_r;
  logic [NUM_BUTTONS-1:0]   hold_en_r;
  logic [NUM_BUTTONS-1:0]   up_en_r;
  logic [CFG_TICK_W+31:0]   dload_wide;
  logic [CFG_TICK_W+31:0]   hload_wide;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= DEBOUNCE_RST;
      hold_ticks_r  <= HOLD_RST;
      pressed_lvl_r <= PRESSED_LVL_RST[NUM_BUTTONS-1:0];
      down_en_r     <= DOWN_EN_RST[NUM_BUTTONS-1:0];
      hold_en_r     <= HOLD_EN_RST[NUM_BUTTONS-1:0];
      up_en_r       <= UP_EN_RST[NUM_BUTTONS-1:0];
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE_TICKS: debounce_r    <= cfg_wdata[CFG_TICK_W-1:0];
        REG_HOLD_TICKS:     hold_ticks_r  <= cfg_wdata[CFG_TICK_W-1:0];
        REG_PRESSED_LEVEL:  pressed_lvl_r <= cfg_wdata[NUM_BUTTONS-1:0];
        REG_DOWN_ENABLE:    down_en_r     <= cfg_wdata[NUM_BUTTONS-1:0];
        REG_HOLD_ENABLE:    hold_en_r     <= cfg_wdata[NUM_BUTTONS-1:0];
        REG_UP_ENABLE:      up_en_r       <= cfg_wdata[NUM_BUTTONS-1:0];
        default: ;
      endcase
    end
  end

  // load values fit to the counter width
  assign dload_wide  = {32'd0, debounce_r};
  assign hload_wide  = {32'd0, hold_ticks_r};
  assign dload       = dload_wide[COUNT_BITS-1:0];
  assign hload       = hload_wide[COUNT_BITS-1:0];
  assign pressed_lvl = pressed_lvl_r;
  assign down_en     = down_en_r;
  assign hold_en     = hold_en_r;
  assign up_en       = up_en_r;

endmodule

`default_nettype wire

### src/mbdh_lane.sv
`default_nettype none

module mbdh_lane #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic                  active,
  input  wire logic [COUNT_BITS-1:0] dload,
  input  wire logic [COUNT_BITS-1:0] hload,
  output      mbdh_pkg::lane_evt_t   evt
);
  import mbdh_pkg::*;

  localparam logic [1:0] PH_UP      = 2'd0;
  localparam logic [1:0] PH_FALLING = 2'd1;
  localparam logic [1:0] PH_DOWN    = 2'd2;
  localparam logic [1:0] PH_RISING  = 2'd3;

  localparam logic [COUNT_BITS-1:0] CNT_ZERO = '0;
  localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

  logic [1:0]            phase_r;
  logic [1:0]            phase_nxt;
  logic [COUNT_BITS-1:0] settle_r;
  logic [COUNT_BITS-1:0] settle_nxt;
  logic [COUNT_BITS-1:0] hold_r;
  logic [COUNT_BITS-1:0] hold_nxt;

  always_comb begin
    phase_nxt      = phase_r;
    settle_nxt     = settle_r;
    hold_nxt       = hold_r;
    evt.press      = 1'b0;
    evt.hold       = 1'b0;
    evt.release_ev = 1'b0;
    case (phase_r)
      PH_UP: begin
        if (active) begin
          settle_nxt = dload;
          phase_nxt  = PH_FALLING;
        end
      end
      PH_FALLING: begin
        if (settle_r == CNT_ZERO) begin
          if (active) begin
            phase_nxt = PH_DOWN;
            evt.press = 1'b1;
            hold_nxt  = hload;
          end else begin
            phase_nxt = PH_UP;
          end
        end else begin
          settle_nxt = settle_r - CNT_ONE;
        end
      end
      PH_DOWN: begin
        if (active) begin
          if (hold_r == CNT_ZERO) begin
            // hold fired, repeat period is the debounce time
            hold_nxt = dload;
            evt.hold = 1'b1;
          end else begin
            hold_nxt = hold_r - CNT_ONE;
          end
        end else begin
          phase_nxt  = PH_RISING;
          settle_nxt = dload;
          hold_nxt   = hload;
        end
      end
      PH_RISING: begin
        if (settle_r == CNT_ZERO) begin
          if (active) begin
            phase_nxt = PH_DOWN;
          end else begin
            phase_nxt      = PH_UP;
            evt.release_ev = 1'b1;
          end
        end else begin
          settle_nxt = settle_r - CNT_ONE;
        end
      end
      default: begin
        phase_nxt = PH_UP;
      end
    endcase
    evt.down = (phase_nxt == PH_DOWN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_UP;
      settle_r <= CNT_ZERO;
      hold_r   <= CNT_ZERO;
    end else if (step) begin
      phase_r  <= phase_nxt;
      settle_r <= settle_nxt;
      hold_r   <= hold_nxt;
    end
  end

`ifndef SYNTH
  a_press_from_settled_fall: assert property (@(posedge clk) disable iff (!rst_n)
    evt.press |-> (phase_r == PH_FALLING && settle_r == CNT_ZERO && active))
    else $error("press without a settled falling phase");

  a_settle_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (phase_r == PH_FALLING || phase_r == PH_RISING) && settle_r != CNT_ZERO)
      |=> (settle_r == $past(settle_r) - CNT_ONE && phase_r == $past(phase_r)))
    else $error("settle counter did not count down");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(phase_r) && $stable(settle_r) && $stable(hold_r)))
    else $error("lane state moved without a tick");
`endif

endmodule

`default_nettype wire
